// ===== hdl/ttst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttst_pkg: shared types and constants of the tick task scheduler table
// Holds the request and response beat layouts, the request and status codes
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ttst_pkg;

	// Number of slots in the table. The slot fields of both beats are three
	// bits wide, so the table size is fixed with them.
	localparam int NUM_TASKS = 8;

	// Request kinds carried in req_type. Codes five to seven do nothing.
	typedef enum logic [2:0] {
		REQ_TICK     = 3'd0,
		REQ_ADD      = 3'd1,
		REQ_DISPATCH = 3'd2,
		REQ_DELETE   = 3'd3,
		REQ_INIT     = 3'd4
	} req_kind_t;

	// Response status codes.
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_DUE   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_ADDED = 2'd3
	} stat_t;

	localparam int PEND_WIDTH = 8;
	localparam logic [PEND_WIDTH-1:0] PEND_MAX = 8'd255;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  slot_index;
		logic [15:0] first_delay;
		logic [15:0] period;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] task_slot;
		logic       last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;  // take the request beat and start it
		logic rd;      // read the slot at the scan index
		logic skip;    // step over a slot that is not live
		logic upd;     // update the slot that was read and step on
		logic fin;     // send the final response of the request
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_scan;    // incoming request walks the table
		logic scan_end;   // scan index has reached the fill mark
		logic slot_live;  // slot at the scan index is valid
		logic upd_go;     // the slot update may complete this cycle
		logic out_free;   // the response register can take a beat
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/tick_task_scheduler_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tick_task_scheduler_table: time triggered cooperative task scheduler table
// A fixed table of task slots aged by tick requests, filled by add requests
// and drained by dispatch requests that report each slot with runs pending.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                  Beat
//   -------   ----------------------   ------------------------------------
//   request   req_valid, req_ready     req: kind, slot, first delay, period
//   response  rsp_valid, rsp_ready     rsp: status, task slot, last flag
//
// Add, delete, init and unknown requests go from the accept state to the
// state that loads the response register. Tick and dispatch walk the
// slots below the fill mark through the single read port of the slot RAM:
// each valid slot is read and then updated, a deleted slot is skipped, and
// the end of the scan loads the response register.
// Reset clears the valid bits and the fill mark at once; the slot RAM needs
// no clearing pass, since a slot that is not valid is never read.
// A response waits in its register while the next request is accepted; a
// stalled response channel holds the walk only when a second due slot is
// found or the final beat is ready to go.
//
// The controller sequences each request. The datapath holds the valid bits,
// fill mark and scan index, the slot RAM with countdown, reload period and
// pending runs of each slot, and one held response. A dispatch keeps its most
// recent due slot in the held response and sends it only when the next due
// slot turns up or the scan ends, so that the final beat carries last set.
// ----------------------------------------------------------------------------
module tick_task_scheduler_table #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ttst_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ttst_pkg::rsp_t      rsp
);
	import ttst_pkg::*;

	// Command and status groups between the sequencer and the table.
	ctl_cmd_t cmd;
	dp_sts_t  sts;

	ttst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttst_dpath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== hdl/ttst_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttst_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttst_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ttst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttst_ctrl: request sequencer of the tick task scheduler table
// Accepts a request, walks the slots for tick and dispatch, and sends the
// final response.
// ----------------------------------------------------------------------------
module ttst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire ttst_pkg::dp_sts_t  sts,
	output ttst_pkg::ctl_cmd_t      cmd
);
	import ttst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RD   = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.in_scan ? ST_RD : ST_FIN;
				end
			end
			ST_RD: begin
				if (sts.scan_end) begin
					state_d = ST_FIN;
				end else if (!sts.slot_live) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (sts.upd_go) begin
					cmd.upd = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ttst_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttst_dpath: slot table datapath of the tick task scheduler table
// Valid bits, fill mark, scan index, slot RAM, held response and the
// response register.
// ----------------------------------------------------------------------------
module ttst_dpath #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ttst_pkg::req_t     req,
	input  wire ttst_pkg::ctl_cmd_t cmd,
	output ttst_pkg::dp_sts_t       sts,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output ttst_pkg::rsp_t          rsp
);
	import ttst_pkg::*;

	localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int FW = $clog2(NUM_TASKS + 1);
	localparam int CW = COUNT_WIDTH;
	localparam int DW = 2 * CW + PEND_WIDTH;

	logic [NUM_TASKS-1:0] valid_q;
	logic [FW-1:0]        fill_q;
	logic [FW-1:0]        idx_q;
	logic                 dispatch_q;
	logic                 hold_due_q;
	logic [1:0]           hold_status_q;
	logic [2:0]           hold_idx_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                  full;
	logic                  is_add, is_del, is_init;
	logic                  del_ok;
	logic [DW-1:0]         rd_data;
	logic [CW-1:0]         rd_cd, rd_per;
	logic [PEND_WIDTH-1:0] rd_pend;
	logic [CW-1:0]         nx_cd;
	logic [PEND_WIDTH-1:0] nx_pend;
	logic                  due;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [DW-1:0]         wr_data;
	logic                  push_mid, push_fin;

	assign full    = (fill_q == FW'(NUM_TASKS));
	assign is_add  = (req.req_type == REQ_ADD);
	assign is_del  = (req.req_type == REQ_DELETE);
	assign is_init = (req.req_type == REQ_INIT);
	assign del_ok  = (32'(req.slot_index) < NUM_TASKS);

	assign {rd_cd, rd_per, rd_pend} = rd_data;
	assign due = dispatch_q && (rd_pend != '0);

	// Tick ages a slot; dispatch uses one pending run.
	always_comb begin
		nx_cd   = rd_cd;
		nx_pend = rd_pend;
		if (dispatch_q) begin
			nx_pend = rd_pend - PEND_WIDTH'(1);
		end else if (rd_cd == '0) begin
			if (rd_pend != PEND_MAX) begin
				nx_pend = rd_pend + PEND_WIDTH'(1);
			end
			if (rd_per != '0) begin
				nx_cd = rd_per;
			end
		end else begin
			nx_cd = rd_cd - CW'(1);
		end
	end

	always_comb begin
		if (cmd.accept) begin
			wr_en   = is_add && !full;
			wr_addr = fill_q[IW-1:0];
			wr_data = {CW'(req.first_delay), CW'(req.period), PEND_WIDTH'(0)};
		end else begin
			wr_en   = cmd.upd && (!dispatch_q || due);
			wr_addr = idx_q[IW-1:0];
			wr_data = {nx_cd, rd_per, nx_pend};
		end
	end

	ttst_ram #(
		.WIDTH(DW),
		.DEPTH(NUM_TASKS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd),
		.rd_addr(idx_q[IW-1:0]),
		.rd_data(rd_data)
	);

	assign push_mid = cmd.upd && due && hold_due_q;
	assign push_fin = cmd.fin;

	assign sts.in_scan   = (req.req_type == REQ_TICK) || (req.req_type == REQ_DISPATCH);
	assign sts.scan_end  = (idx_q >= fill_q);
	assign sts.slot_live = valid_q[idx_q[IW-1:0]];
	assign sts.out_free  = !out_valid_q || rsp_ready;
	assign sts.upd_go    = !(due && hold_due_q && !sts.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			dispatch_q  <= 1'b0;
			hold_due_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				idx_q      <= '0;
				dispatch_q <= (req.req_type == REQ_DISPATCH);
				hold_due_q <= 1'b0;
				if (is_init) begin
					valid_q <= '0;
					fill_q  <= '0;
				end else if (is_add && !full) begin
					valid_q[fill_q[IW-1:0]] <= 1'b1;
					fill_q                  <= fill_q + FW'(1);
				end else if (is_del && del_ok) begin
					valid_q[IW'(req.slot_index)] <= 1'b0;
				end
			end
			if (cmd.skip || cmd.upd) begin
				idx_q <= idx_q + FW'(1);
			end
			if (cmd.upd && due) begin
				hold_due_q <= 1'b1;
				if (rd_per == '0) begin
					valid_q[idx_q[IW-1:0]] <= 1'b0;
				end
			end
			if (push_mid || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hold_idx_q <= '0;
			if (is_add) begin
				hold_status_q <= full ? STAT_FULL : STAT_ADDED;
				hold_idx_q    <= full ? 3'd0 : 3'(fill_q);
			end else begin
				hold_status_q <= STAT_DONE;
			end
		end else if (cmd.upd && due) begin
			hold_status_q <= STAT_DUE;
			hold_idx_q    <= 3'(idx_q);
		end
		if (push_mid || push_fin) begin
			out_q.status    <= hold_status_q;
			out_q.task_slot <= hold_idx_q;
			out_q.last      <= push_fin;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(NUM_TASKS))
		else $error("fill mark beyond table size");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push_mid || push_fin) |-> sts.out_free)
		else $error("response pushed over an untaken beat");

	a_valid_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q >> fill_q) == '0)
		else $error("valid slot at or above fill mark");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (!sts.scan_end && sts.slot_live))
		else $error("slot read outside the live range");
`endif

endmodule
`default_nettype wire
